@@ src/tflp_pkg.sv @@
`default_nettype none

package tflp_pkg;

  // Field widths.
  localparam int TEMP_W     = 19;
  localparam int DUTY_W     = 7;
  localparam int FAN_MASK_W = 6;
  localparam int TBL_LEN    = 8;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [DUTY_W-1:0]        duty_t;

  // Fan levels.
  typedef enum logic [1:0] {
    LVL_INIT = 2'd0,
    LVL_DEF  = 2'd1,
    LVL_MID  = 2'd2,
    LVL_MAX  = 2'd3
  } level_t;

  // Duty cycles in percent.
  localparam duty_t DUTY_FULL = 7'd100;
  localparam duty_t DUTY_HIGH = 7'd75;
  localparam duty_t DUTY_LOW  = 7'd50;
  localparam duty_t DUTY_NONE = 7'd0;

  // Per-sensor thresholds in millidegrees, back-to-front airflow.
  localparam temp_t B2F_UP [TBL_LEN] = '{
    19'sd61500, 19'sd51500, 19'sd49400, 19'sd49400,
    19'sd45100, 19'sd46750, 19'sd48000, 19'sd38500};
  localparam temp_t B2F_DOWN [TBL_LEN] = '{
    19'sd57000, 19'sd47300, 19'sd45000, 19'sd45100,
    19'sd40750, 19'sd42100, 19'sd44000, 19'sd35000};

  // Per-sensor thresholds in millidegrees, front-to-back airflow.
  localparam temp_t F2B_DEF_MID [TBL_LEN] = '{
    19'sd67000, 19'sd62000, 19'sd65000, 19'sd59000,
    19'sd58500, 19'sd63000, 19'sd69000, 19'sd49000};
  localparam temp_t F2B_MID_MAX [TBL_LEN] = '{
    19'sd70000, 19'sd66000, 19'sd68000, 19'sd62000,
    19'sd62000, 19'sd67000, 19'sd77000, 19'sd50000};
  localparam temp_t F2B_MAX_MID [TBL_LEN] = '{
    19'sd59000, 19'sd53500, 19'sd55300, 19'sd50300,
    19'sd50000, 19'sd52500, 19'sd59000, 19'sd41100};
  localparam temp_t F2B_MID_DEF [TBL_LEN] = '{
    19'sd55800, 19'sd50500, 19'sd51100, 19'sd47600,
    19'sd45750, 19'sd50100, 19'sd57000, 19'sd36600};

  // What one sensor lane found for the selected airflow direction.
  typedef struct packed {
    logic raise_mid;   // at or above the default-to-mid threshold
    logic raise_max;   // at or above the raise-to-max threshold
    logic lower_a;     // at or below the lowering threshold from max
    logic lower_b;     // at or below the mid-to-default threshold
  } lane_flags_t;

  // Outcome of one tick.
  typedef struct packed {
    logic   duty_write;
    duty_t  duty_value;
    level_t level;
    logic   fail;
  } step_result_t;

  // Duty that belongs to a level; zero where the level has none.
  function automatic duty_t level_duty(input level_t lvl, input logic b2f);
    duty_t d;
    d = DUTY_NONE;
    case (lvl)
      LVL_DEF: d = b2f ? DUTY_HIGH : DUTY_LOW;
      LVL_MID: d = b2f ? DUTY_NONE : DUTY_HIGH;
      LVL_MAX: d = DUTY_FULL;
      default: d = DUTY_NONE;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/tflp_lane.sv @@
`default_nettype none

module tflp_lane
  import tflp_pkg::*;
#(
  parameter int LANE_IDX = 0
) (
  input  wire temp_t       temp,
  input  wire logic        back_to_front,
  output lane_flags_t      flags
);

  logic b2f_up, b2f_down;
  logic f2b_mid, f2b_max, f2b_max_mid, f2b_mid_def;

  // Threshold compares for this sensor.
  assign b2f_up      = temp >= B2F_UP[LANE_IDX];
  assign b2f_down    = temp <= B2F_DOWN[LANE_IDX];
  assign f2b_mid     = temp >= F2B_DEF_MID[LANE_IDX];
  assign f2b_max     = temp >= F2B_MID_MAX[LANE_IDX];
  assign f2b_max_mid = temp <= F2B_MAX_MID[LANE_IDX];
  assign f2b_mid_def = temp <= F2B_MID_DEF[LANE_IDX];

  // Select the set that the airflow direction uses.
  always_comb begin
    if (back_to_front) begin
      flags.raise_mid = 1'b0;
      flags.raise_max = b2f_up;
      flags.lower_a   = b2f_down;
      flags.lower_b   = 1'b0;
    end else begin
      flags.raise_mid = f2b_mid;
      flags.raise_max = f2b_max;
      flags.lower_a   = f2b_max_mid;
      flags.lower_b   = f2b_mid_def;
    end
  end

endmodule

`default_nettype wire

@@ src/tflp_merge.sv @@
`default_nettype none

module tflp_merge
  import tflp_pkg::*;
#(
  parameter int NUM_LANES = 8
) (
  input  wire lane_flags_t [NUM_LANES-1:0] flags,
  input  wire logic                        back_to_front,
  input  wire logic                        fan_bad,
  input  wire logic                        sensor_error,
  input  wire duty_t                       duty_now,
  input  wire level_t                      level_cur,
  input  wire logic                        fail_cur,
  output step_result_t                     result
);

  logic   any_mid, any_max, all_a, all_b;
  level_t lvl;
  logic   fail_next;
  duty_t  new_duty;

  // Reduce the lane findings.
  always_comb begin
    any_mid = 1'b0;
    any_max = 1'b0;
    all_a   = 1'b1;
    all_b   = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      any_mid = any_mid | flags[i].raise_mid;
      any_max = any_max | flags[i].raise_max;
      all_a   = all_a & flags[i].lower_a;
      all_b   = all_b & flags[i].lower_b;
    end
  end

  // Next level. A hot sensor that selects max wins over every other sensor, so the
  // lowering conditions only count when no sensor reached max.
  always_comb begin
    lvl = (level_cur == LVL_INIT) ? LVL_DEF : level_cur;
    if (any_max) begin
      lvl = LVL_MAX;
    end else if (back_to_front) begin
      if (all_a && level_cur == LVL_MAX) lvl = LVL_DEF;
    end else begin
      if (any_mid && (lvl == LVL_INIT || lvl == LVL_DEF)) lvl = LVL_MID;
      if (all_a && level_cur == LVL_MAX) lvl = LVL_MID;
      if (all_b && level_cur == LVL_MID) lvl = LVL_DEF;
    end
  end

  assign fail_next = fail_cur | fan_bad;
  assign new_duty  = level_duty(lvl, back_to_front);

  // Duty write decision.
  always_comb begin
    result.duty_write = 1'b0;
    result.duty_value = DUTY_NONE;
    result.level      = lvl;
    result.fail       = fail_next;
    if (sensor_error) begin
      result.duty_write = 1'b1;
      result.duty_value = DUTY_HIGH;
      result.level      = level_cur;
      result.fail       = fail_cur;
    end else begin
      if (fan_bad && duty_now != DUTY_FULL) begin
        result.duty_write = 1'b1;
        result.duty_value = DUTY_FULL;
      end
      if (lvl != level_cur && !fail_next) begin
        if (new_duty == DUTY_NONE) begin
          result.duty_write = 1'b1;
          result.duty_value = DUTY_FULL;
        end else if (new_duty != duty_now) begin
          result.duty_write = 1'b1;
          result.duty_value = new_duty;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/thermal_fan_level_policy_top.sv @@
// Thermal fan level policy.
// Item channel (item_valid/item_ready): one tick of eight sensor temperatures,
// airflow direction, bad fan mask, sensor error flag and the applied duty.
// Result channel (result_valid/result_ready): duty write request, duty value,
// fan level and latched fan failure flag after the tick.
// Sensor compares, the lane merge and the level update are combinational and
// the result is registered at the item transfer, so one item transfers per
// cycle while the receiver keeps up. The level register and the
// fail latch update at the item transfer, so the next tick sees them at once.
// The result register holds its contents while the receiver stalls; a new item
// is taken in the same cycle that the held result transfers.
// Reset sets the fan level to init, clears the fail latch and empties the
// result register.
`default_nettype none

module thermal_fan_level_policy_top
  import tflp_pkg::*;
#(
  parameter int NUM_SENSORS = 8,
  parameter int NUM_FANS    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_ready,
  input  wire logic signed [TEMP_W-1:0] temp_s0,
  input  wire logic signed [TEMP_W-1:0] temp_s1,
  input  wire logic signed [TEMP_W-1:0] temp_s2,
  input  wire logic signed [TEMP_W-1:0] temp_s3,
  input  wire logic signed [TEMP_W-1:0] temp_s4,
  input  wire logic signed [TEMP_W-1:0] temp_s5,
  input  wire logic signed [TEMP_W-1:0] temp_s6,
  input  wire logic signed [TEMP_W-1:0] temp_s7,
  input  wire logic                     back_to_front,
  input  wire logic [FAN_MASK_W-1:0]    fan_bad_mask,
  input  wire logic                     sensor_error,
  input  wire logic [DUTY_W-1:0]        duty_now,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output logic                          duty_write,
  output logic [DUTY_W-1:0]             duty_value,
  output logic [1:0]                    level_out,
  output logic                          fail_out
);

  localparam int NumLanes = (NUM_SENSORS < TBL_LEN) ? NUM_SENSORS : TBL_LEN;
  localparam int FanBits  = (NUM_FANS < FAN_MASK_W) ? NUM_FANS : FAN_MASK_W;
  localparam logic [FAN_MASK_W-1:0] FanMask =
    FAN_MASK_W'((64'd1 << FanBits) - 64'd1);

  temp_t                      temps [TBL_LEN];
  lane_flags_t [NumLanes-1:0] flags;
  step_result_t               step;
  level_t                     fan_level;
  logic                       fail_latched;
  logic                       item_xfer;
  logic                       fan_bad;

  assign temps[0] = temp_s0;
  assign temps[1] = temp_s1;
  assign temps[2] = temp_s2;
  assign temps[3] = temp_s3;
  assign temps[4] = temp_s4;
  assign temps[5] = temp_s5;
  assign temps[6] = temp_s6;
  assign temps[7] = temp_s7;

  // One compare lane per sensor in use.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    tflp_lane #(
      .LANE_IDX (g)
    ) u_lane (
      .temp          (temps[g]),
      .back_to_front (back_to_front),
      .flags         (flags[g])
    );
  end

  assign fan_bad = |(fan_bad_mask & FanMask);

  // Merge lanes with the current state.
  tflp_merge #(
    .NUM_LANES (NumLanes)
  ) u_merge (
    .flags         (flags),
    .back_to_front (back_to_front),
    .fan_bad       (fan_bad),
    .sensor_error  (sensor_error),
    .duty_now      (duty_now),
    .level_cur     (fan_level),
    .fail_cur      (fail_latched),
    .result        (step)
  );

  assign item_ready = !result_valid || result_ready;
  assign item_xfer  = item_valid && item_ready;

  // Policy state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_level    <= LVL_INIT;
      fail_latched <= 1'b0;
    end else if (item_xfer) begin
      fan_level    <= step.level;
      fail_latched <= step.fail;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_xfer) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      duty_write <= step.duty_write;
      duty_value <= step.duty_value;
      level_out  <= step.level;
      fail_out   <= step.fail;
    end
  end

  // A sensor error always requests the high duty.
  a_sensor_error_duty: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && sensor_error) |=>
      (result_valid && duty_write && duty_value == DUTY_HIGH))
    else $error("sensor error did not request high duty");

  // The fail latch never clears outside reset.
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    fail_latched |=> fail_latched)
    else $error("fan fail latch cleared");

  // Once the level leaves init it never returns there.
  a_level_no_init: assert property (@(posedge clk) disable iff (rst)
    (fan_level != LVL_INIT) |=> (fan_level != LVL_INIT))
    else $error("fan level returned to init");

  // A result without a write carries a zero duty.
  a_idle_duty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !duty_write) |-> (duty_value == DUTY_NONE))
    else $error("nonzero duty without write");

  // The registered result matches the state it reports.
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> (level_out == fan_level && fail_out == fail_latched))
    else $error("result does not match policy state");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tflp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 4;

  // Rows of the per-sensor threshold table.
  typedef enum int {
    ROW_B2F_UP,
    ROW_B2F_DOWN,
    ROW_F2B_TO_MID,
    ROW_F2B_TO_MAX,
    ROW_F2B_MAX_TO_MID,
    ROW_F2B_MID_TO_DEF
  } thr_row_t;

  // One tick as presented on the item channel.
  typedef struct packed {
    logic [TBL_LEN-1:0][TEMP_W-1:0] temp;
    logic                           b2f;
    logic [FAN_MASK_W-1:0]          mask;
    logic                           serr;
    duty_t                          duty;
  } tick_t;

  // One fan decision as seen on the result channel.
  typedef struct packed {
    logic   wr;
    duty_t  val;
    level_t lvl;
    logic   fail;
  } fan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  item_valid = 1'b0;
  logic                  item_ready;
  logic [TEMP_W-1:0]     temp_s0 = '0;
  logic [TEMP_W-1:0]     temp_s1 = '0;
  logic [TEMP_W-1:0]     temp_s2 = '0;
  logic [TEMP_W-1:0]     temp_s3 = '0;
  logic [TEMP_W-1:0]     temp_s4 = '0;
  logic [TEMP_W-1:0]     temp_s5 = '0;
  logic [TEMP_W-1:0]     temp_s6 = '0;
  logic [TEMP_W-1:0]     temp_s7 = '0;
  logic                  back_to_front = 1'b0;
  logic [FAN_MASK_W-1:0] fan_bad_mask = '0;
  logic                  sensor_error = 1'b0;
  logic [DUTY_W-1:0]     duty_now = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic                  duty_write;
  logic [DUTY_W-1:0]     duty_value;
  logic [1:0]            level_out;
  logic                  fail_out;

  // Thresholds in millidegrees, one row per comparison and one column per sensor.
  int thr_mc [6][8] = '{
    '{61500, 51500, 49400, 49400, 45100, 46750, 48000, 38500},
    '{57000, 47300, 45000, 45100, 40750, 42100, 44000, 35000},
    '{67000, 62000, 65000, 59000, 58500, 63000, 69000, 49000},
    '{70000, 66000, 68000, 62000, 62000, 67000, 77000, 50000},
    '{59000, 53500, 55300, 50300, 50000, 52500, 59000, 41100},
    '{55800, 50500, 51100, 47600, 45750, 50100, 57000, 36600}
  };

  // Predicted fan state and the duty the fans would run at.
  level_t level_q      = LVL_INIT;
  logic   fail_q       = 1'b0;
  duty_t  applied_duty = DUTY_NONE;

  fan_result_t pending_results [$];
  int          fail_count  = 0;
  int          cycle_count = 0;
  logic        flow_b2f    = 1'b0;
  logic        source_gaps = 1'b1;
  logic        sink_stalls = 1'b1;
  int          sink_hold   = 0;

  thermal_fan_level_policy_top DUT (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .temp_s0       (temp_s0),
    .temp_s1       (temp_s1),
    .temp_s2       (temp_s2),
    .temp_s3       (temp_s3),
    .temp_s4       (temp_s4),
    .temp_s5       (temp_s5),
    .temp_s6       (temp_s6),
    .temp_s7       (temp_s7),
    .back_to_front (back_to_front),
    .fan_bad_mask  (fan_bad_mask),
    .sensor_error  (sensor_error),
    .duty_now      (duty_now),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .duty_write    (duty_write),
    .duty_value    (duty_value),
    .level_out     (level_out),
    .fail_out      (fail_out)
  );

  always #6 clk = ~clk;

  // Advance the fan state by one tick and return the decision it produces.
  function automatic fan_result_t fan_step(input tick_t k);
    fan_result_t r;
    level_t      orig;
    level_t      nxt;
    duty_t       nd;
    int          v;
    int          below_a;
    int          below_b;
    logic        hit_max;
    r       = '0;
    orig    = level_q;
    below_a = 0;
    below_b = 0;
    hit_max = 1'b0;

    // A failed read asks for the high duty and leaves the state alone.
    if (k.serr) begin
      r.wr   = 1'b1;
      r.val  = DUTY_HIGH;
      r.lvl  = orig;
      r.fail = fail_q;
      return r;
    end

    nxt = (orig == LVL_INIT) ? LVL_DEF : orig;

    // Scan the sensors in order; the first one at a max threshold ends the scan.
    for (int i = 0; i < TBL_LEN; i++) begin
      if (!hit_max) begin
        v = $signed(k.temp[i]);
        if (k.b2f) begin
          if (v >= thr_mc[ROW_B2F_UP][i]) begin
            nxt     = LVL_MAX;
            hit_max = 1'b1;
          end else if (v <= thr_mc[ROW_B2F_DOWN][i]) begin
            below_a++;
          end
        end else begin
          if (v >= thr_mc[ROW_F2B_TO_MID][i] && nxt < LVL_MID) nxt = LVL_MID;
          if (v >= thr_mc[ROW_F2B_TO_MAX][i]) begin
            nxt     = LVL_MAX;
            hit_max = 1'b1;
          end else begin
            if (v <= thr_mc[ROW_F2B_MAX_TO_MID][i]) below_a++;
            if (v <= thr_mc[ROW_F2B_MID_TO_DEF][i]) below_b++;
          end
        end
      end
    end

    // Lowering needs every sensor at or below its threshold.
    if (k.b2f) begin
      if (below_a == TBL_LEN && orig == LVL_MAX) nxt = LVL_DEF;
    end else begin
      if (below_a == TBL_LEN && orig == LVL_MAX) nxt = LVL_MID;
      if (below_b == TBL_LEN && orig == LVL_MID) nxt = LVL_DEF;
    end

    // A bad fan forces full duty and latches the failure.
    if (k.mask != '0) begin
      if (k.duty != DUTY_FULL) begin
        r.wr  = 1'b1;
        r.val = DUTY_FULL;
      end
      fail_q = 1'b1;
    end

    // A level change writes its duty unless the failure latch mutes it.
    if (nxt != orig) begin
      if (nxt == LVL_MAX) nd = DUTY_FULL;
      else if (nxt == LVL_MID) nd = k.b2f ? DUTY_NONE : DUTY_HIGH;
      else if (nxt == LVL_DEF) nd = k.b2f ? DUTY_HIGH : DUTY_LOW;
      else nd = DUTY_NONE;
      level_q = nxt;
      if (!fail_q) begin
        if (nd == DUTY_NONE) begin
          r.wr  = 1'b1;
          r.val = DUTY_FULL;
        end else if (nd != k.duty) begin
          r.wr  = 1'b1;
          r.val = nd;
        end
      end
    end

    r.lvl  = level_q;
    r.fail = fail_q;
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // A temperature on or close to one threshold of one sensor.
  function automatic int near_threshold(input thr_row_t row, input int sensor);
    int base;
    int p;
    base = thr_mc[row][sensor];
    p    = $urandom_range(0, 9);
    if (p < 3) return base;
    if (p < 6) return ($urandom_range(0, 1) != 0) ? base + 1 : base - 1;
    return base + int'($urandom_range(0, 6000)) - 3000;
  endfunction

  // All sensors well below every lowering threshold.
  function automatic tick_t quiet_tick(input logic b2f, input duty_t duty);
    tick_t k;
    k = '0;
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(20000);
    k.b2f  = b2f;
    k.duty = duty;
    return k;
  endfunction

  // A random tick; temperatures cluster around thresholds so that levels move.
  function automatic tick_t random_tick(input logic with_bad_fans);
    tick_t    k;
    int       style;
    int       v;
    int       p;
    thr_row_t low_row;
    k     = '0;
    style = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 4) flow_b2f = ~flow_b2f;
    k.b2f = flow_b2f;

    for (int i = 0; i < TBL_LEN; i++) begin
      if (style < 30) begin
        // Cool tick, some sensors sitting on a lowering threshold.
        v = int'($urandom_range(0, 75000)) - 40000;
        if ($urandom_range(0, 3) == 0) begin
          p = $urandom_range(0, 2);
          if (p == 0) low_row = ROW_B2F_DOWN;
          else if (p == 1) low_row = ROW_F2B_MAX_TO_MID;
          else low_row = ROW_F2B_MID_TO_DEF;
          v = near_threshold(low_row, i);
        end
      end else if (style < 75) begin
        if ($urandom_range(0, 9) < 6) v = near_threshold(thr_row_t'($urandom_range(0, 5)), i);
        else v = int'($urandom_range(0, 60000)) - 40000;
      end else if (style < 92) begin
        v = int'($urandom_range(0, 190000)) - 40000;
      end else begin
        v = int'($urandom_range(0, (1 << TEMP_W) - 1));
      end
      k.temp[i] = temp_t'(v);
    end

    k.serr = ($urandom_range(0, 99) < 6);
    if (with_bad_fans && $urandom_range(0, 9) < 4) k.mask = FAN_MASK_W'($urandom_range(1, 63));

    p = $urandom_range(0, 99);
    if (p < 50) begin
      k.duty = applied_duty;
    end else if (p < 80) begin
      case ($urandom_range(0, 2))
        0:       k.duty = DUTY_LOW;
        1:       k.duty = DUTY_HIGH;
        default: k.duty = DUTY_FULL;
      endcase
    end else if (p < 95) begin
      k.duty = duty_t'($urandom_range(0, 100));
    end else begin
      k.duty = duty_t'($urandom_range(0, 127));
    end
    return k;
  endfunction

  // Present one tick after an optional gap and wait for its transfer.
  task automatic send_tick(input tick_t k);
    int gap;
    gap = source_gaps ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    temp_s0       <= k.temp[0];
    temp_s1       <= k.temp[1];
    temp_s2       <= k.temp[2];
    temp_s3       <= k.temp[3];
    temp_s4       <= k.temp[4];
    temp_s5       <= k.temp[5];
    temp_s6       <= k.temp[6];
    temp_s7       <= k.temp[7];
    back_to_front <= k.b2f;
    fan_bad_mask  <= k.mask;
    sensor_error  <= k.serr;
    duty_now      <= k.duty;
    item_valid    <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // Stop sending until every outstanding decision has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Read failures before the first level is chosen, with one hot sensor and with all sensors cold.
  task automatic test_sensor_error();
    tick_t k;
    k         = quiet_tick(1'b0, DUTY_NONE);
    k.serr    = 1'b1;
    k.temp[6] = temp_t'(150000);
    send_tick(k);
    k         = quiet_tick(1'b1, DUTY_HIGH);
    k.serr    = 1'b1;
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(-40000);
    send_tick(k);
  endtask

  // Front-to-back: leave init, climb through mid to max, then step back down.
  task automatic test_front_to_back();
    tick_t k;
    send_tick(quiet_tick(1'b0, DUTY_NONE));
    k         = quiet_tick(1'b0, DUTY_LOW);
    k.temp[3] = temp_t'(thr_mc[ROW_F2B_TO_MID][3]);
    send_tick(k);
    k         = quiet_tick(1'b0, DUTY_HIGH);
    k.temp[0] = temp_t'(thr_mc[ROW_F2B_TO_MID][0]);
    k.temp[7] = temp_t'(thr_mc[ROW_F2B_TO_MAX][7]);
    send_tick(k);
    // A mid-level reading must not pull max down.
    k         = quiet_tick(1'b0, DUTY_FULL);
    k.temp[6] = temp_t'(thr_mc[ROW_F2B_TO_MID][6]);
    send_tick(k);
    k = quiet_tick(1'b0, DUTY_FULL);
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(thr_mc[ROW_F2B_MAX_TO_MID][i]);
    send_tick(k);
    k = quiet_tick(1'b0, DUTY_HIGH);
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(thr_mc[ROW_F2B_MID_TO_DEF][i]);
    k.temp[2] = temp_t'(thr_mc[ROW_F2B_MID_TO_DEF][2] + 1);
    send_tick(k);
    // Level drops to default with the duty already applied: no write.
    k.temp[2] = temp_t'(thr_mc[ROW_F2B_MID_TO_DEF][2]);
    k.duty    = DUTY_LOW;
    send_tick(k);
  endtask

  // Back-to-front: two levels, and a mid level held over from the other airflow.
  task automatic test_back_to_front();
    tick_t k;
    send_tick(quiet_tick(1'b1, DUTY_LOW));
    k         = quiet_tick(1'b1, DUTY_HIGH);
    k.temp[7] = temp_t'(thr_mc[ROW_B2F_UP][7]);
    send_tick(k);
    k = quiet_tick(1'b1, DUTY_FULL);
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(thr_mc[ROW_B2F_DOWN][i]);
    k.temp[2] = temp_t'(thr_mc[ROW_B2F_DOWN][2] + 1);
    send_tick(k);
    k.temp[2] = temp_t'(thr_mc[ROW_B2F_DOWN][2]);
    send_tick(k);
    k         = quiet_tick(1'b0, DUTY_HIGH);
    k.temp[4] = temp_t'(thr_mc[ROW_F2B_TO_MID][4]);
    send_tick(k);
    send_tick(quiet_tick(1'b1, DUTY_HIGH));
    k         = quiet_tick(1'b1, DUTY_HIGH);
    k.temp[1] = temp_t'(thr_mc[ROW_B2F_UP][1]);
    send_tick(k);
  endtask

  // Temperatures at the ends of the field and of the sensor range, stray duty.
  task automatic test_field_extremes();
    tick_t k;
    k = quiet_tick(1'b0, duty_t'(127));
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(-(1 << (TEMP_W - 1)));
    send_tick(k);
    k         = quiet_tick(1'b0, DUTY_FULL);
    k.temp[0] = temp_t'((1 << (TEMP_W - 1)) - 1);
    send_tick(k);
    k = quiet_tick(1'b0, duty_t'(127));
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(-40000);
    send_tick(k);
    k = quiet_tick(1'b0, DUTY_FULL);
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(150000);
    send_tick(k);
  endtask

  // Random ticks in stretches with different idle behavior on each side.
  task automatic test_random_ticks(input int count, input logic with_bad_fans);
    for (int n = 0; n < count; n++) begin
      if (n % 120 == 0) begin
        case ($urandom_range(0, 3))
          0:       begin source_gaps = 1'b0; sink_stalls = 1'b0; end
          1:       begin source_gaps = 1'b1; sink_stalls = 1'b1; end
          2:       begin source_gaps = 1'b1; sink_stalls = 1'b0; end
          default: begin source_gaps = 1'b0; sink_stalls = 1'b1; end
        endcase
      end
      if (!with_bad_fans && n == count / 2) hold_until_drained();
      send_tick(random_tick(with_bad_fans));
    end
  endtask

  // Bad fans: forced full duty, latched failure, muted level writes.
  task automatic test_fan_failure();
    tick_t k;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    k      = quiet_tick(1'b0, DUTY_LOW);
    k.serr = 1'b1;
    k.mask = '1;
    send_tick(k);
    k         = quiet_tick(1'b0, DUTY_FULL);
    k.mask    = FAN_MASK_W'(6'h20);
    k.temp[7] = temp_t'(thr_mc[ROW_F2B_TO_MAX][7]);
    send_tick(k);
    k = quiet_tick(1'b0, DUTY_FULL);
    for (int i = 0; i < TBL_LEN; i++) k.temp[i] = temp_t'(-40000);
    send_tick(k);
    k      = quiet_tick(1'b0, DUTY_LOW);
    k.mask = FAN_MASK_W'(6'h01);
    send_tick(k);
  endtask

  // Wait for the last decisions, then report.
  task automatic finish_run();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d decisions never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  endtask

  // Result side: stall at random while stalls are enabled.
  always @(negedge clk) begin
    if (!sink_stalls) begin
      result_ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      result_ready <= 1'b0;
    end else begin
      sink_hold = idle_length();
      result_ready <= (sink_hold == 0);
      if (sink_hold > 0) sink_hold--;
    end
  end

  // Check each result transfer, then predict from each item transfer.
  always @(posedge clk) begin : scoreboard
    fan_result_t want;
    fan_result_t seen;
    tick_t       k;
    if (!rst) begin
      if (result_valid && result_ready) begin
        seen.wr   = duty_write;
        seen.val  = duty_value;
        seen.lvl  = level_t'(level_out);
        seen.fail = fail_out;
        if (pending_results.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (seen.wr !== want.wr) begin
            $error("duty_write: expected %0d, got %0d", want.wr, seen.wr);
            fail_count++;
          end
          if (seen.val !== want.val) begin
            $error("duty_value: expected %0d, got %0d", want.val, seen.val);
            fail_count++;
          end
          if (seen.lvl !== want.lvl) begin
            $error("level_out: expected %0d, got %0d", want.lvl, seen.lvl);
            fail_count++;
          end
          if (seen.fail !== want.fail) begin
            $error("fail_out: expected %0d, got %0d", want.fail, seen.fail);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) begin
        k.temp[0] = temp_s0;
        k.temp[1] = temp_s1;
        k.temp[2] = temp_s2;
        k.temp[3] = temp_s3;
        k.temp[4] = temp_s4;
        k.temp[5] = temp_s5;
        k.temp[6] = temp_s6;
        k.temp[7] = temp_s7;
        k.b2f     = back_to_front;
        k.mask    = fan_bad_mask;
        k.serr    = sensor_error;
        k.duty    = duty_now;
        want      = fan_step(k);
        if (want.wr) applied_duty = want.val;
        pending_results.push_back(want);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_sensor_error();
    test_front_to_back();
    test_back_to_front();
    test_field_extremes();
    test_random_ticks(900, 1'b0);
    test_fan_failure();
    test_random_ticks(180, 1'b1);
    finish_run();
  end

endmodule

@@ filelist.f @@
src/tflp_pkg.sv
src/tflp_lane.sv
src/tflp_merge.sv
src/thermal_fan_level_policy_top.sv
sim/testbench.sv
